FILE: rtl/crg_pkg.sv
// Shared types, codes and constants for the continued-fraction relation generator.
`timescale 1ns / 1ps
`default_nettype none

package crg_pkg;

    localparam int DIV_W          = 50;
    localparam int MOD_W          = 32;
    localparam int VAL_W          = 17;
    localparam int ROOT_W         = 16;
    localparam int PRIME_W        = 8;
    localparam int LEN_SHORT      = 18;
    localparam int LEN_MID        = 32;
    localparam int CNT_W          = 6;
    localparam int CFG_IDX_W      = 3;
    localparam int NUM_PRIME_REGS = 3;
    localparam int FACTOR_PRIMES  = 3;

    localparam logic [1:0] PRIMES_USED =
        2'((FACTOR_PRIMES < NUM_PRIME_REGS) ? FACTOR_PRIMES : NUM_PRIME_REGS);

    localparam logic [VAL_W-1:0]   MAX17 = 17'h1FFFF;

    localparam logic [MOD_W-1:0]   SQUARE_VALUE_RST = 32'd9073;
    localparam logic [ROOT_W-1:0]  ROOT_FLOOR_RST   = 16'd95;
    localparam logic [MOD_W-1:0]   MODULUS_RST      = 32'd1739;
    localparam logic [PRIME_W-1:0] PRIME_A_RST      = 8'd2;
    localparam logic [PRIME_W-1:0] PRIME_B_RST      = 8'd3;
    localparam logic [PRIME_W-1:0] PRIME_C_RST      = 8'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SQUARE_VALUE,
        CFG_ROOT_FLOOR,
        CFG_MODULUS,
        CFG_PRIME_A,
        CFG_PRIME_B,
        CFG_PRIME_C
    } cfg_index_t;

    typedef enum logic [1:0] {
        DIV_LEN_SHORT,
        DIV_LEN_MID,
        DIV_LEN_FULL
    } div_len_t;

    typedef struct packed {
        logic             start;
        div_len_t         len;
        logic [DIV_W-1:0] dividend;
        logic [MOD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [MOD_W-1:0] remainder;
    } div_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ST_GO,
        S_ST_WAIT,
        S_ST_MUL,
        S_ST_MOD_GO,
        S_ST_MOD_WAIT,
        S_SQ_MUL,
        S_VN_GO,
        S_VN_WAIT,
        S_A_GO,
        S_A_WAIT,
        S_UN_MUL,
        S_UN_SET,
        S_P_MUL,
        S_P_GO,
        S_P_WAIT,
        S_R_GO,
        S_R_WAIT,
        S_TR_GO,
        S_TR_WAIT,
        S_OUT
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/crg_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module crg_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire crg_pkg::div_req_t req,
    output crg_pkg::div_rsp_t      rsp
);

    logic [crg_pkg::DIV_W-1:0] dvd_reg, dvd_next;
    logic [crg_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [crg_pkg::MOD_W-1:0] rem_reg, rem_next;
    logic [crg_pkg::MOD_W-1:0] dsr_reg, dsr_next;
    logic [crg_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;

    logic [crg_pkg::MOD_W:0]   rem_sh;
    logic [crg_pkg::MOD_W:0]   rem_sub;
    logic                      fits;

    assign rem_sh  = {rem_reg, dvd_reg[crg_pkg::DIV_W-1]};
    assign fits    = (rem_sh >= {1'b0, dsr_reg});
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = '0;
            dsr_next  = req.divisor;
            busy_next = 1'b1;
            case (req.len)
                crg_pkg::DIV_LEN_SHORT:
                begin
                    dvd_next = {req.dividend[crg_pkg::LEN_SHORT-1:0],
                                {(crg_pkg::DIV_W-crg_pkg::LEN_SHORT){1'b0}}};
                    cnt_next = crg_pkg::CNT_W'(crg_pkg::LEN_SHORT);
                end
                crg_pkg::DIV_LEN_MID:
                begin
                    dvd_next = {req.dividend[crg_pkg::LEN_MID-1:0],
                                {(crg_pkg::DIV_W-crg_pkg::LEN_MID){1'b0}}};
                    cnt_next = crg_pkg::CNT_W'(crg_pkg::LEN_MID);
                end
                default:
                begin
                    dvd_next = req.dividend;
                    cnt_next = crg_pkg::CNT_W'(crg_pkg::DIV_W);
                end
            endcase
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[crg_pkg::DIV_W-2:0], 1'b0};
            rem_next = fits ? rem_sub[crg_pkg::MOD_W-1:0] : rem_sh[crg_pkg::MOD_W-1:0];
            quo_next = {quo_reg[crg_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == crg_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

FILE: rtl/cfrac_relation_generator_core.sv
// Top level of the continued-fraction relation generator: sequencer, multiplier and state.
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_ready   mode, start_u, start_v
//  result    out        out_valid / out_ready partial_quotient ... smooth
//  config    in         cfg_write_en          cfg_index, cfg_data
//
// A start transaction runs up to two 18-bit divisions on the shared one-bit-per-cycle divider.
// A step transaction runs divisions of 32, 18, 50 and 18 bits plus one 18-bit division per trial
// division, and skips primes below 2; a zero modulus or denominator skips some divisions.
// in_ready is high only while the sequencer is idle and returns the cycle after a result loads.
// A finished result waits in the output register while the next transaction is taken;
// the sequencer holds its next result until that register is free.
// Reset restores the register defaults and the expansion state; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module cfrac_relation_generator_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                mode,
    input  wire logic [crg_pkg::ROOT_W-1:0]          start_u,
    input  wire logic [crg_pkg::VAL_W-1:0]           start_v,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [crg_pkg::VAL_W-1:0]                partial_quotient,
    output logic [crg_pkg::MOD_W-1:0]                numerator_mod,
    output logic                                     has_residue,
    output logic signed [crg_pkg::MOD_W:0]           residue,
    output logic                                     residue_negative,
    output logic                                     parity_a,
    output logic                                     parity_b,
    output logic                                     parity_c,
    output logic                                     smooth,
    input  wire logic                                cfg_write_en,
    input  wire logic [crg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [crg_pkg::MOD_W-1:0]           cfg_data
);

    localparam int PROD_W = crg_pkg::MOD_W + crg_pkg::VAL_W;

    crg_pkg::state_t state_reg, state_next;

    logic [crg_pkg::MOD_W-1:0]   square_value_reg;
    logic [crg_pkg::ROOT_W-1:0]  root_floor_reg;
    logic [crg_pkg::MOD_W-1:0]   modulus_reg;
    logic [crg_pkg::PRIME_W-1:0] prime_a_reg, prime_b_reg, prime_c_reg;

    logic [crg_pkg::VAL_W-1:0]   offset_u_reg, offset_u_next;
    logic [crg_pkg::VAL_W-1:0]   denom_v_reg, denom_v_next;
    logic [crg_pkg::MOD_W-1:0]   num_prev_reg, num_prev_next;
    logic [crg_pkg::MOD_W-1:0]   num_cur_reg, num_cur_next;
    logic                        step_parity_reg, step_parity_next;

    logic                        mode_reg, mode_next;
    logic [crg_pkg::VAL_W-1:0]   quot_reg, quot_next;
    logic [crg_pkg::VAL_W-1:0]   vn_reg, vn_next;
    logic [crg_pkg::VAL_W-1:0]   res_reg, res_next;
    logic [crg_pkg::VAL_W-1:0]   mag_reg, mag_next;
    logic [2:0]                  par_reg, par_next;
    logic [1:0]                  pidx_reg, pidx_next;
    logic [PROD_W-1:0]           prod_reg;

    logic [crg_pkg::MOD_W-1:0]   mul_a;
    logic [crg_pkg::VAL_W-1:0]   mul_b;

    logic                        out_valid_reg, out_valid_next;
    logic [crg_pkg::VAL_W-1:0]   pq_reg;
    logic [crg_pkg::MOD_W-1:0]   nm_reg;
    logic                        has_reg;
    logic [crg_pkg::MOD_W:0]     residue_reg;
    logic                        neg_reg;
    logic [2:0]                  par_out_reg;
    logic                        smooth_reg;

    crg_pkg::div_req_t           div_req;
    crg_pkg::div_rsp_t           div_rsp;

    logic                        in_take;
    logic                        out_free;
    logic                        load_out;
    logic                        mod_zero;
    logic                        start_skip;
    logic                        vn_skip;
    logic                        prime_low;
    logic                        trial_end;
    logic [crg_pkg::PRIME_W-1:0] prime_sel;
    logic                        neg_now;
    logic [crg_pkg::MOD_W:0]     res_ext;
    logic [crg_pkg::VAL_W-1:0]   q_vn_sat;
    logic [crg_pkg::VAL_W-1:0]   q_a_sat;
    logic [crg_pkg::VAL_W:0]     rf_plus_u;
    logic [crg_pkg::VAL_W-1:0]   rf_minus_u;
    logic [2*crg_pkg::VAL_W-1:0] un_diff;
    logic [crg_pkg::VAL_W-1:0]   un_val;
    logic [crg_pkg::DIV_W-1:0]   p_sum;

    crg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ready   = (state_reg == crg_pkg::S_IDLE);
    assign in_take    = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign load_out   = (state_reg == crg_pkg::S_OUT) && out_free;
    assign mod_zero   = (modulus_reg == '0);
    assign start_skip = (offset_u_reg > {1'b0, root_floor_reg}) || (denom_v_reg == '0);
    assign vn_skip    = (denom_v_reg == '0) ||
                        ({2'b00, square_value_reg} <= prod_reg[2*crg_pkg::VAL_W-1:0]);
    assign prime_low  = (prime_sel < crg_pkg::PRIME_W'(2));
    assign trial_end  = (mag_reg == '0) || (pidx_reg >= crg_pkg::PRIMES_USED);

    assign rf_minus_u = {1'b0, root_floor_reg} - offset_u_reg;
    assign rf_plus_u  = {2'b00, root_floor_reg} + {1'b0, offset_u_reg};
    assign q_vn_sat   = (div_rsp.quotient[crg_pkg::MOD_W-1:crg_pkg::VAL_W] != '0) ?
                        crg_pkg::MAX17 : div_rsp.quotient[crg_pkg::VAL_W-1:0];
    assign q_a_sat    = div_rsp.quotient[crg_pkg::VAL_W] ?
                        crg_pkg::MAX17 : div_rsp.quotient[crg_pkg::VAL_W-1:0];
    assign un_diff    = prod_reg[2*crg_pkg::VAL_W-1:0] - {{crg_pkg::VAL_W{1'b0}}, offset_u_reg};
    assign un_val     = (prod_reg[2*crg_pkg::VAL_W-1:0] <= {{crg_pkg::VAL_W{1'b0}}, offset_u_reg})
                        ? '0
                        : ((un_diff[2*crg_pkg::VAL_W-1:crg_pkg::VAL_W] != '0) ?
                           crg_pkg::MAX17 : un_diff[crg_pkg::VAL_W-1:0]);
    assign p_sum      = {1'b0, prod_reg} + {{(crg_pkg::DIV_W-crg_pkg::MOD_W){1'b0}}, num_prev_reg};

    assign neg_now    = mode_reg && !step_parity_reg && (res_reg != '0);
    assign res_ext    = {{(crg_pkg::MOD_W+1-crg_pkg::VAL_W){1'b0}}, res_reg};

    always_comb
    begin
        case (pidx_reg)
            2'd0:    prime_sel = prime_a_reg;
            2'd1:    prime_sel = prime_b_reg;
            2'd2:    prime_sel = prime_c_reg;
            default: prime_sel = '0;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            crg_pkg::S_ST_MUL:
            begin
                mul_a = {{(crg_pkg::MOD_W-crg_pkg::VAL_W){1'b0}}, quot_reg};
                mul_b = denom_v_reg;
            end
            crg_pkg::S_SQ_MUL:
            begin
                mul_a = {{(crg_pkg::MOD_W-crg_pkg::VAL_W){1'b0}}, offset_u_reg};
                mul_b = offset_u_reg;
            end
            crg_pkg::S_UN_MUL:
            begin
                mul_a = {{(crg_pkg::MOD_W-crg_pkg::VAL_W){1'b0}}, quot_reg};
                mul_b = vn_reg;
            end
            crg_pkg::S_P_MUL:
            begin
                mul_a = num_cur_reg;
                mul_b = quot_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crg_pkg::S_IDLE:
                if (in_valid)
                    state_next = mode ? crg_pkg::S_SQ_MUL : crg_pkg::S_ST_GO;
            crg_pkg::S_ST_GO:
                state_next = start_skip ? crg_pkg::S_ST_MUL : crg_pkg::S_ST_WAIT;
            crg_pkg::S_ST_WAIT:
                if (div_rsp.done)
                    state_next = crg_pkg::S_ST_MUL;
            crg_pkg::S_ST_MUL:
                state_next = crg_pkg::S_ST_MOD_GO;
            crg_pkg::S_ST_MOD_GO:
                state_next = mod_zero ? crg_pkg::S_OUT : crg_pkg::S_ST_MOD_WAIT;
            crg_pkg::S_ST_MOD_WAIT:
                if (div_rsp.done)
                    state_next = crg_pkg::S_OUT;
            crg_pkg::S_SQ_MUL:
                state_next = crg_pkg::S_VN_GO;
            crg_pkg::S_VN_GO:
                state_next = vn_skip ? crg_pkg::S_A_GO : crg_pkg::S_VN_WAIT;
            crg_pkg::S_VN_WAIT:
                if (div_rsp.done)
                    state_next = crg_pkg::S_A_GO;
            crg_pkg::S_A_GO:
                state_next = (vn_reg == '0) ? crg_pkg::S_UN_MUL : crg_pkg::S_A_WAIT;
            crg_pkg::S_A_WAIT:
                if (div_rsp.done)
                    state_next = crg_pkg::S_UN_MUL;
            crg_pkg::S_UN_MUL:
                state_next = crg_pkg::S_UN_SET;
            crg_pkg::S_UN_SET:
                state_next = crg_pkg::S_P_MUL;
            crg_pkg::S_P_MUL:
                state_next = crg_pkg::S_P_GO;
            crg_pkg::S_P_GO:
                state_next = mod_zero ? crg_pkg::S_R_GO : crg_pkg::S_P_WAIT;
            crg_pkg::S_P_WAIT:
                if (div_rsp.done)
                    state_next = crg_pkg::S_R_GO;
            crg_pkg::S_R_GO:
                state_next = mod_zero ? crg_pkg::S_TR_GO : crg_pkg::S_R_WAIT;
            crg_pkg::S_R_WAIT:
                if (div_rsp.done)
                    state_next = crg_pkg::S_TR_GO;
            crg_pkg::S_TR_GO:
                if (trial_end)
                    state_next = crg_pkg::S_OUT;
                else if (!prime_low)
                    state_next = crg_pkg::S_TR_WAIT;
            crg_pkg::S_TR_WAIT:
                if (div_rsp.done)
                    state_next = crg_pkg::S_TR_GO;
            crg_pkg::S_OUT:
                if (out_free)
                    state_next = crg_pkg::S_IDLE;
            default:
                state_next = crg_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        offset_u_next    = offset_u_reg;
        denom_v_next     = denom_v_reg;
        num_prev_next    = num_prev_reg;
        num_cur_next     = num_cur_reg;
        step_parity_next = step_parity_reg;
        mode_next        = mode_reg;
        quot_next        = quot_reg;
        vn_next          = vn_reg;
        res_next         = res_reg;
        mag_next         = mag_reg;
        par_next         = par_reg;
        pidx_next        = pidx_reg;
        div_req          = '0;
        case (state_reg)
            crg_pkg::S_IDLE:
                if (in_take)
                begin
                    mode_next = mode;
                    if (!mode)
                    begin
                        offset_u_next    = {1'b0, start_u};
                        denom_v_next     = start_v;
                        num_prev_next    = crg_pkg::MOD_W'(1);
                        step_parity_next = 1'b0;
                    end
                end
            crg_pkg::S_ST_GO:
                if (start_skip)
                    quot_next = '0;
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.len      = crg_pkg::DIV_LEN_SHORT;
                    div_req.dividend = crg_pkg::DIV_W'(rf_minus_u);
                    div_req.divisor  = crg_pkg::MOD_W'(denom_v_reg);
                end
            crg_pkg::S_ST_WAIT:
                if (div_rsp.done)
                    quot_next = div_rsp.quotient[crg_pkg::VAL_W-1:0];
            crg_pkg::S_ST_MOD_GO:
            begin
                offset_u_next = offset_u_reg + prod_reg[crg_pkg::VAL_W-1:0];
                if (mod_zero)
                    num_cur_next = crg_pkg::MOD_W'(quot_reg);
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.len      = crg_pkg::DIV_LEN_SHORT;
                    div_req.dividend = crg_pkg::DIV_W'(quot_reg);
                    div_req.divisor  = modulus_reg;
                end
            end
            crg_pkg::S_ST_MOD_WAIT:
                if (div_rsp.done)
                    num_cur_next = div_rsp.remainder;
            crg_pkg::S_VN_GO:
                if (vn_skip)
                    vn_next = '0;
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.len      = crg_pkg::DIV_LEN_MID;
                    div_req.dividend = crg_pkg::DIV_W'(square_value_reg -
                                                       prod_reg[crg_pkg::MOD_W-1:0]);
                    div_req.divisor  = crg_pkg::MOD_W'(denom_v_reg);
                end
            crg_pkg::S_VN_WAIT:
                if (div_rsp.done)
                    vn_next = q_vn_sat;
            crg_pkg::S_A_GO:
                if (vn_reg == '0)
                    quot_next = '0;
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.len      = crg_pkg::DIV_LEN_SHORT;
                    div_req.dividend = crg_pkg::DIV_W'(rf_plus_u);
                    div_req.divisor  = crg_pkg::MOD_W'(vn_reg);
                end
            crg_pkg::S_A_WAIT:
                if (div_rsp.done)
                    quot_next = q_a_sat;
            crg_pkg::S_UN_SET:
            begin
                offset_u_next = un_val;
                denom_v_next  = vn_reg;
            end
            crg_pkg::S_P_GO:
                if (mod_zero)
                begin
                    num_prev_next = num_cur_reg;
                    num_cur_next  = p_sum[crg_pkg::MOD_W-1:0];
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.len      = crg_pkg::DIV_LEN_FULL;
                    div_req.dividend = p_sum;
                    div_req.divisor  = modulus_reg;
                end
            crg_pkg::S_P_WAIT:
                if (div_rsp.done)
                begin
                    num_prev_next = num_cur_reg;
                    num_cur_next  = div_rsp.remainder;
                end
            crg_pkg::S_R_GO:
            begin
                pidx_next = '0;
                par_next  = '0;
                if (mod_zero)
                begin
                    res_next = vn_reg;
                    mag_next = vn_reg;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.len      = crg_pkg::DIV_LEN_SHORT;
                    div_req.dividend = crg_pkg::DIV_W'(vn_reg);
                    div_req.divisor  = modulus_reg;
                end
            end
            crg_pkg::S_R_WAIT:
                if (div_rsp.done)
                begin
                    res_next = div_rsp.remainder[crg_pkg::VAL_W-1:0];
                    mag_next = div_rsp.remainder[crg_pkg::VAL_W-1:0];
                end
            crg_pkg::S_TR_GO:
                if (!trial_end)
                begin
                    if (prime_low)
                        pidx_next = pidx_reg + 2'd1;
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.len      = crg_pkg::DIV_LEN_SHORT;
                        div_req.dividend = crg_pkg::DIV_W'(mag_reg);
                        div_req.divisor  = crg_pkg::MOD_W'(prime_sel);
                    end
                end
            crg_pkg::S_TR_WAIT:
                if (div_rsp.done)
                begin
                    if (div_rsp.remainder == '0)
                    begin
                        mag_next = div_rsp.quotient[crg_pkg::VAL_W-1:0];
                        par_next = par_reg ^ 3'(3'b001 << pidx_reg);
                    end
                    else
                        pidx_next = pidx_reg + 2'd1;
                end
            crg_pkg::S_OUT:
                if (out_free && mode_reg)
                    step_parity_next = !step_parity_reg;
            default:
                ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= crg_pkg::S_IDLE;
            square_value_reg <= crg_pkg::SQUARE_VALUE_RST;
            root_floor_reg   <= crg_pkg::ROOT_FLOOR_RST;
            modulus_reg      <= crg_pkg::MODULUS_RST;
            prime_a_reg      <= crg_pkg::PRIME_A_RST;
            prime_b_reg      <= crg_pkg::PRIME_B_RST;
            prime_c_reg      <= crg_pkg::PRIME_C_RST;
            offset_u_reg     <= '0;
            denom_v_reg      <= crg_pkg::VAL_W'(1);
            num_prev_reg     <= crg_pkg::MOD_W'(1);
            num_cur_reg      <= '0;
            step_parity_reg  <= 1'b0;
            mode_reg         <= 1'b0;
            pidx_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            offset_u_reg    <= offset_u_next;
            denom_v_reg     <= denom_v_next;
            num_prev_reg    <= num_prev_next;
            num_cur_reg     <= num_cur_next;
            step_parity_reg <= step_parity_next;
            mode_reg        <= mode_next;
            pidx_reg        <= pidx_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_write_en)
            begin
                case (cfg_index)
                    crg_pkg::CFG_SQUARE_VALUE: square_value_reg <= cfg_data;
                    crg_pkg::CFG_ROOT_FLOOR:   root_floor_reg   <= cfg_data[crg_pkg::ROOT_W-1:0];
                    crg_pkg::CFG_MODULUS:      modulus_reg      <= cfg_data;
                    crg_pkg::CFG_PRIME_A:      prime_a_reg      <= cfg_data[crg_pkg::PRIME_W-1:0];
                    crg_pkg::CFG_PRIME_B:      prime_b_reg      <= cfg_data[crg_pkg::PRIME_W-1:0];
                    crg_pkg::CFG_PRIME_C:      prime_c_reg      <= cfg_data[crg_pkg::PRIME_W-1:0];
                    default:                   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        vn_reg   <= vn_next;
        res_reg  <= res_next;
        mag_reg  <= mag_next;
        par_reg  <= par_next;
        prod_reg <= mul_a * mul_b;
        if (load_out)
        begin
            pq_reg      <= quot_reg;
            nm_reg      <= num_cur_reg;
            has_reg     <= mode_reg;
            neg_reg     <= neg_now;
            residue_reg <= !mode_reg ? '0 : (neg_now ? (~res_ext + 1'b1) : res_ext);
            par_out_reg <= mode_reg ? par_reg : 3'b000;
            smooth_reg  <= mode_reg && (mag_reg == crg_pkg::VAL_W'(1));
        end
    end

    assign out_valid        = out_valid_reg;
    assign partial_quotient = pq_reg;
    assign numerator_mod    = nm_reg;
    assign has_residue      = has_reg;
    assign residue          = residue_reg;
    assign residue_negative = neg_reg;
    assign parity_a         = par_out_reg[0];
    assign parity_b         = par_out_reg[1];
    assign parity_c         = par_out_reg[2];
    assign smooth           = smooth_reg;

endmodule

`default_nettype wire

FILE: rtl/crg_checker.sv
// Port-level checks for the relation generator core and their bind.
`timescale 1ns / 1ps
`default_nettype none

module crg_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic [crg_pkg::VAL_W-1:0]     partial_quotient,
    input  wire logic [crg_pkg::MOD_W-1:0]     numerator_mod,
    input  wire logic                          has_residue,
    input  wire logic signed [crg_pkg::MOD_W:0] residue,
    input  wire logic                          residue_negative,
    input  wire logic                          parity_a,
    input  wire logic                          parity_b,
    input  wire logic                          parity_c,
    input  wire logic                          smooth
);

    // drop ready for the cycle after a transaction is taken
    ap_busy_after_take: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("input taken while previous transaction still in work");

    ap_start_clean: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !has_residue) |->
            (residue == '0) && !residue_negative && !smooth &&
            !parity_a && !parity_b && !parity_c
    ) else $error("start result carries residue fields");

    ap_sign_match: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (residue_negative == residue[crg_pkg::MOD_W])
    ) else $error("residue sign flag disagrees with residue");

    ap_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            out_valid && $stable(partial_quotient) && $stable(numerator_mod) &&
            $stable(residue)
    ) else $error("stalled result changed");

endmodule

bind cfrac_relation_generator_core crg_checker u_crg_checker (.*);

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the continued-fraction relation generator core.
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic [crg_pkg::VAL_W-1:0]      quotient;
        logic [crg_pkg::MOD_W-1:0]      numerator;
        logic                           has_res;
        logic signed [crg_pkg::MOD_W:0] res;
        logic                           res_neg;
        logic                           par_a;
        logic                           par_b;
        logic                           par_c;
        logic                           smooth_flag;
    } relation_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic                           mode = 1'b0;
    logic [crg_pkg::ROOT_W-1:0]     start_u = '0;
    logic [crg_pkg::VAL_W-1:0]      start_v = 17'd1;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [crg_pkg::VAL_W-1:0]      partial_quotient;
    logic [crg_pkg::MOD_W-1:0]      numerator_mod;
    logic                           has_residue;
    logic signed [crg_pkg::MOD_W:0] residue;
    logic                           residue_negative;
    logic                           parity_a;
    logic                           parity_b;
    logic                           parity_c;
    logic                           smooth;
    logic                           cfg_write_en = 1'b0;
    crg_pkg::cfg_index_t            cfg_index = crg_pkg::CFG_SQUARE_VALUE;
    logic [crg_pkg::MOD_W-1:0]      cfg_data = '0;

    logic [crg_pkg::MOD_W-1:0]      cf_square = crg_pkg::SQUARE_VALUE_RST;
    logic [crg_pkg::ROOT_W-1:0]     cf_root = crg_pkg::ROOT_FLOOR_RST;
    logic [crg_pkg::MOD_W-1:0]      cf_modulus = crg_pkg::MODULUS_RST;
    logic [crg_pkg::PRIME_W-1:0]    cf_prime [crg_pkg::NUM_PRIME_REGS] =
        '{crg_pkg::PRIME_A_RST, crg_pkg::PRIME_B_RST, crg_pkg::PRIME_C_RST};
    logic [crg_pkg::VAL_W-1:0]      cf_offset = '0;
    logic [crg_pkg::VAL_W-1:0]      cf_denom = 17'd1;
    logic [crg_pkg::MOD_W-1:0]      conv_prev = 32'd1;
    logic [crg_pkg::MOD_W-1:0]      conv_cur = '0;
    logic                           odd_step = 1'b0;

    relation_t               relations_due [$];
    relation_t               due_rel;
    int                      mismatch_count = 0;
    bit                      feed_active = 1'b0;
    bit                      sender_idle_en = 1'b0;
    bit                      receiver_idle_en = 1'b0;
    int                      stall_left = 0;

    cfrac_relation_generator_core uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .start_u          (start_u),
        .start_v          (start_v),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .partial_quotient (partial_quotient),
        .numerator_mod    (numerator_mod),
        .has_residue      (has_residue),
        .residue          (residue),
        .residue_negative (residue_negative),
        .parity_a         (parity_a),
        .parity_b         (parity_b),
        .parity_c         (parity_c),
        .smooth           (smooth),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic [63:0] reduce_mod(logic [63:0] x);
        if (cf_modulus == 0)
            return x & 64'hFFFF_FFFF;
        return x % 64'(cf_modulus);
    endfunction

    function automatic logic [63:0] clamp17(logic [63:0] x);
        return (x > 64'(crg_pkg::MAX17)) ? 64'(crg_pkg::MAX17) : x;
    endfunction

    function automatic relation_t expand_relation(logic m, logic [crg_pkg::ROOT_W-1:0] u,
                                                  logic [crg_pkg::VAL_W-1:0] v);
        relation_t                          rel;
        logic [63:0]                        sq;
        logic [63:0]                        vn;
        logic [63:0]                        a;
        logic [63:0]                        un;
        logic [63:0]                        pn;
        logic [63:0]                        r;
        logic [63:0]                        mag;
        logic [63:0]                        p;
        logic [crg_pkg::NUM_PRIME_REGS-1:0] par;
        logic [crg_pkg::MOD_W:0]            res_bits;
        logic                               neg;
        rel = '{default: '0};
        if (!m)
        begin
            a = (u > cf_root || v == 0) ? 64'd0 : 64'(cf_root - u) / 64'(v);
            cf_offset = crg_pkg::VAL_W'(64'(u) + a * 64'(v));
            cf_denom  = v;
            conv_prev = 32'd1;
            conv_cur  = crg_pkg::MOD_W'(reduce_mod(a));
            odd_step  = 1'b0;
            rel.quotient  = crg_pkg::VAL_W'(a);
            rel.numerator = conv_cur;
            return rel;
        end
        sq = 64'(cf_offset) * 64'(cf_offset);
        if (cf_denom == 0 || 64'(cf_square) <= sq)
            vn = 64'd0;
        else
            vn = clamp17((64'(cf_square) - sq) / 64'(cf_denom));
        a = (vn == 0) ? 64'd0 : clamp17((64'(cf_root) + 64'(cf_offset)) / vn);
        un = a * vn;
        un = (un > 64'(cf_offset)) ? clamp17(un - 64'(cf_offset)) : 64'd0;
        cf_offset = crg_pkg::VAL_W'(un);
        cf_denom  = crg_pkg::VAL_W'(vn);
        pn = reduce_mod(64'(conv_cur) * a + 64'(conv_prev));
        conv_prev = conv_cur;
        conv_cur  = crg_pkg::MOD_W'(pn);
        r   = reduce_mod(vn);
        neg = !odd_step && r != 0;
        mag = r;
        par = '0;
        if (mag != 0)
            for (int k = 0; k < crg_pkg::NUM_PRIME_REGS && k < crg_pkg::FACTOR_PRIMES; k++)
            begin
                p = 64'(cf_prime[k]);
                if (p >= 2)
                    while (mag % p == 0)
                    begin
                        mag = mag / p;
                        par[k] = ~par[k];
                    end
            end
        res_bits = neg ? ~r[crg_pkg::MOD_W:0] + 1'b1 : r[crg_pkg::MOD_W:0];
        rel.quotient    = crg_pkg::VAL_W'(a);
        rel.numerator   = crg_pkg::MOD_W'(pn);
        rel.has_res     = 1'b1;
        rel.res         = res_bits;
        rel.res_neg     = neg;
        rel.par_a       = par[0];
        rel.par_b       = par[1];
        rel.par_c       = par[2];
        rel.smooth_flag = (mag == 1);
        odd_step = ~odd_step;
        return rel;
    endfunction

    function automatic logic [crg_pkg::ROOT_W-1:0] floor_root(logic [crg_pkg::MOD_W-1:0] d);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = crg_pkg::ROOT_W - 1; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= 64'(d))
                r = t;
        end
        return crg_pkg::ROOT_W'(r);
    endfunction

    function automatic logic [crg_pkg::PRIME_W-1:0] pick_prime();
        logic [crg_pkg::PRIME_W-1:0] small_primes [12] =
            '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
        if ($urandom_range(0, 3) != 0)
            return small_primes[$urandom_range(0, 11)];
        return crg_pkg::PRIME_W'($urandom_range(2, 255));
    endfunction

    function automatic void check_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // drop valid and hold until every transaction has produced its result
    task automatic drain_results();
        if (feed_active)
        begin
            in_valid <= 1'b0;
            feed_active = 1'b0;
        end
        while (relations_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_item(logic m, logic [crg_pkg::ROOT_W-1:0] u,
                             logic [crg_pkg::VAL_W-1:0] v);
        if (sender_idle_en && $urandom_range(0, 2) == 0)
        begin
            if (feed_active)
            begin
                in_valid <= 1'b0;
                feed_active = 1'b0;
            end
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        feed_active = 1'b1;
        mode    <= m;
        start_u <= u;
        start_v <= v;
        do
            @(posedge clk);
        while (!in_ready);
        relations_due.push_back(expand_relation(m, u, v));
    endtask

    task automatic run_expansion(int steps, logic [crg_pkg::ROOT_W-1:0] u,
                                 logic [crg_pkg::VAL_W-1:0] v);
        send_item(1'b0, u, v);
        repeat (steps)
            send_item(1'b1, crg_pkg::ROOT_W'($urandom), crg_pkg::VAL_W'($urandom));
    endtask

    task automatic write_reg(crg_pkg::cfg_index_t idx, logic [crg_pkg::MOD_W-1:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        case (idx)
            crg_pkg::CFG_SQUARE_VALUE: cf_square   = val;
            crg_pkg::CFG_ROOT_FLOOR:   cf_root     = crg_pkg::ROOT_W'(val);
            crg_pkg::CFG_MODULUS:      cf_modulus  = val;
            crg_pkg::CFG_PRIME_A:      cf_prime[0] = crg_pkg::PRIME_W'(val);
            crg_pkg::CFG_PRIME_B:      cf_prime[1] = crg_pkg::PRIME_W'(val);
            crg_pkg::CFG_PRIME_C:      cf_prime[2] = crg_pkg::PRIME_W'(val);
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [crg_pkg::MOD_W-1:0] sq,
                                  logic [crg_pkg::ROOT_W-1:0] root,
                                  logic [crg_pkg::MOD_W-1:0] m,
                                  logic [crg_pkg::PRIME_W-1:0] pa,
                                  logic [crg_pkg::PRIME_W-1:0] pb,
                                  logic [crg_pkg::PRIME_W-1:0] pc);
        drain_results();
        write_reg(crg_pkg::CFG_SQUARE_VALUE, sq);
        write_reg(crg_pkg::CFG_ROOT_FLOOR, 32'(root));
        write_reg(crg_pkg::CFG_MODULUS, m);
        write_reg(crg_pkg::CFG_PRIME_A, 32'(pa));
        write_reg(crg_pkg::CFG_PRIME_B, 32'(pb));
        write_reg(crg_pkg::CFG_PRIME_C, 32'(pc));
        cfg_write_en <= 1'b0;
    endtask

    task automatic random_settings();
        logic [crg_pkg::MOD_W-1:0]  sq;
        logic [crg_pkg::MOD_W-1:0]  m;
        logic [crg_pkg::ROOT_W-1:0] root;
        int                         nb;
        nb = $urandom_range(2, 32);
        sq = $urandom >> (32 - nb);
        if (sq < 2)
            sq = 32'd2;
        root = floor_root(sq);
        case ($urandom_range(0, 9))
            0: root = crg_pkg::ROOT_W'($urandom_range(1, 65535));
            1: if (root != 16'hFFFF) root = root + 1'b1;
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: m = $urandom;
            5, 6, 7:       m = $urandom_range(2, 200);
            default:       m = $urandom_range(2, 131071);
        endcase
        if (m < 2)
            m = 32'd2;
        apply_settings(sq, root, m, pick_prime(), pick_prime(), pick_prime());
    endtask

    task automatic test_reset_state();
        sender_idle_en   = 1'b1;
        receiver_idle_en = 1'b1;
        run_expansion(3, 16'd0, 17'd1);
        run_expansion(2, 16'd96, 17'd1);
        run_expansion(1, 16'd0, 17'd0);
        run_expansion(1, 16'hFFFF, 17'h1FFFF);
        run_expansion(1, 16'd95, 17'h1FFFF);
    endtask

    task automatic test_register_extremes();
        apply_settings(32'd2, 16'd1, 32'd2, 8'd2, 8'd2, 8'd2);
        run_expansion(2, 16'd0, 17'd1);
        apply_settings(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'd255, 8'd255, 8'd255);
        run_expansion(3, 16'd0, 17'd1);
        // root set low on purpose: the next denominator saturates and reduces to zero
        apply_settings(32'hFFFF_FFFF, 16'd60000, 32'd131071, 8'd2, 8'd3, 8'd5);
        run_expansion(1, 16'd0, 17'd1);
    endtask

    task automatic test_random_expansions();
        int sent;
        int steps;
        for (int ph = 0; ph < 45; ph++)
        begin
            sender_idle_en   = ($urandom_range(0, 3) != 0);
            receiver_idle_en = ($urandom_range(0, 3) != 0);
            random_settings();
            sent = 0;
            while (sent < 30)
            begin
                steps = $urandom_range(3, 30);
                case ($urandom_range(0, 9))
                    0:
                    begin
                        steps = $urandom_range(0, 4);
                        run_expansion(steps, crg_pkg::ROOT_W'($urandom),
                                      crg_pkg::VAL_W'($urandom_range(1, 131071)));
                    end
                    1:
                    begin
                        steps = $urandom_range(1, 4);
                        repeat (steps)
                            send_item(1'b1, crg_pkg::ROOT_W'($urandom),
                                      crg_pkg::VAL_W'($urandom));
                        steps = steps - 1;
                    end
                    2: run_expansion(steps, crg_pkg::ROOT_W'($urandom_range(0, cf_root)),
                                     crg_pkg::VAL_W'($urandom_range(1, 16)));
                    default: run_expansion(steps, 16'd0, 17'd1);
                endcase
                sent += steps + 1;
            end
        end
    endtask

    task automatic test_drain_and_resume();
        sender_idle_en   = 1'b1;
        receiver_idle_en = 1'b1;
        run_expansion(12, 16'd0, 17'd1);
        drain_results();
        repeat (12)
            send_item(1'b1, crg_pkg::ROOT_W'($urandom), crg_pkg::VAL_W'($urandom));
    endtask

    task automatic test_back_to_back();
        sender_idle_en   = 1'b0;
        receiver_idle_en = 1'b0;
        random_settings();
        repeat (4) run_expansion(20, 16'd0, 17'd1);
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (receiver_idle_en && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 10);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (relations_due.size() == 0)
            begin
                $display("%0t: result with no transaction pending", $time);
                mismatch_count++;
            end
            else
            begin
                due_rel = relations_due.pop_front();
                check_field("partial_quotient", due_rel.quotient, partial_quotient);
                check_field("numerator_mod", due_rel.numerator, numerator_mod);
                check_field("has_residue", due_rel.has_res, has_residue);
                check_field("residue", due_rel.res, residue);
                check_field("residue_negative", due_rel.res_neg, residue_negative);
                check_field("parity_a", due_rel.par_a, parity_a);
                check_field("parity_b", due_rel.par_b, parity_b);
                check_field("parity_c", due_rel.par_c, parity_c);
                check_field("smooth", due_rel.smooth_flag, smooth);
            end
        end
    end

    initial
    begin
        #30_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_register_extremes();
        test_random_expansions();
        test_drain_and_resume();
        test_back_to_back();
        drain_results();
        repeat (300) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
